### rtl/decimal_digit_histogram_defines.svh
// Assertion macros of the decimal digit histogram RTL, used by its back end.
`ifndef DECIMAL_DIGIT_HISTOGRAM_DEFINES_SVH
`define DECIMAL_DIGIT_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, disabled in reset.
`define DDH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge, disabled in reset.
`define DDH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/ddh_pkg.sv
// Package with the widths, constants and types of the decimal digit histogram.
package ddh_pkg;

  localparam int CounterW   = 32;
  localparam int NumberW    = 32;
  localparam int TallyW     = 32;
  localparam int DigitW     = 4;
  localparam int NumDigits  = 10;
  localparam int Radix      = 10;
  localparam int QueueDepth = 2;
  localparam int MagW       = NumberW - 1;

  // Reciprocal of ten, scaled by 2^RecipShift and rounded up. With this shift
  // the product gives the exact quotient for every value below 2^NumberW.
  localparam int RecipShift = NumberW + 3;
  localparam logic [RecipShift:0] RecipNum =
      {1'b1, {RecipShift{1'b0}}} + (RecipShift + 1)'(Radix - 1);
  localparam logic [NumberW:0] Recip = (NumberW + 1)'(RecipNum / Radix);

  // One queued word: the end-of-session flag and the magnitude bits.
  typedef struct packed {
    logic            is_end;
    logic [MagW-1:0] mag;
  } item_t;

endpackage

### rtl/ddh_front.sv
// Front end: accepts and classifies input words and queues them for the back end.
module ddh_front
  import ddh_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [NumberW-1:0] number_i,
  output logic                      busy_o,
  output logic                      item_valid_o,
  output item_t                     item_o,
  input  logic                      item_pop_i
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;
  item_t           item_in;

  assign busy_o       = (cnt_q == CntW'(QueueDepth));
  assign item_valid_o = (cnt_q != '0);
  assign push         = start_i && !busy_o;
  assign pop          = item_pop_i && item_valid_o;

  // The sign bit marks the end of a session; the rest is the magnitude.
  assign item_in.is_end = number_i[NumberW-1];
  assign item_in.mag    = number_i[MagW-1:0];
  assign item_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

### rtl/ddh_back.sv
// Back end: digit extraction, digit counters and the session result sequencer.
`include "decimal_digit_histogram_defines.svh"

module ddh_back
  import ddh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  item_t             item_i,
  output logic              item_pop_o,
  output logic              valid_o,
  output logic              kind_o,
  output logic [DigitW-1:0] digit_o,
  output logic [TallyW-1:0] tally_o,
  output logic              last_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StDigits = 2'd1;
  localparam logic [1:0] StEmit   = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [MagW-1:0]      val_q, val_d;
  logic [DigitW-1:0]    idx_q, idx_d;
  logic                 pend_v_q, pend_v_d;
  logic [DigitW-1:0]    pend_d_q, pend_d_d;
  logic [CounterW-1:0]  cnt_q [NumDigits];
  logic [CounterW-1:0]  num_q;
  logic [NumDigits-1:0] mask_q;
  logic                 clear;
  logic                 count_number;

  logic [2*NumberW-1:0] prod;
  logic [MagW-1:0]      quot;
  logic [MagW-1:0]      rem;

  logic                 res_v;
  logic                 res_kind;
  logic [DigitW-1:0]    res_digit;
  logic [CounterW-1:0]  res_cnt;
  logic                 res_last;
  logic [DigitW-1:0]    rd_idx;

  logic                 valid_q;
  logic                 kind_q;
  logic [DigitW-1:0]    digit_q;
  logic [TallyW-1:0]    tally_q;
  logic                 last_q;

  function automatic logic [CounterW-1:0] sat_inc(input logic [CounterW-1:0] c);
    sat_inc = (c == '1) ? c : c + 1'b1;
  endfunction

  // One quotient and remainder by ten per cycle, by reciprocal multiplication.
  assign prod = {{(NumberW + 1){1'b0}}, val_q} * {{(NumberW - 1){1'b0}}, Recip};
  assign quot = MagW'(prod[2*NumberW-1:RecipShift]);
  assign rem  = val_q - ((quot << 3) + (quot << 1));

  assign item_pop_o = (state_q == StIdle) && item_valid_i;

  always_comb begin
    state_d      = state_q;
    val_d        = val_q;
    idx_d        = idx_q;
    pend_v_d     = 1'b0;
    pend_d_d     = pend_d_q;
    clear        = 1'b0;
    count_number = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          if (item_i.is_end) begin
            idx_d   = '0;
            state_d = StEmit;
          end else begin
            val_d        = item_i.mag;
            count_number = 1'b1;
            state_d      = StDigits;
          end
        end
      end
      StDigits: begin
        pend_v_d = 1'b1;
        pend_d_d = DigitW'(rem);
        val_d    = quot;
        if (quot == '0) begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == DigitW'(NumDigits)) begin
          clear   = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Result of the current sequencer step: the number count first, then each
  // digit in turn, shown only where its counter is nonzero.
  assign rd_idx    = idx_q - 1'b1;
  assign res_kind  = (idx_q != '0);
  assign res_digit = res_kind ? rd_idx : '0;
  assign res_cnt   = res_kind ? cnt_q[rd_idx] : num_q;
  assign res_v     = (state_q == StEmit) && (!res_kind || mask_q[rd_idx]);
  assign res_last  = ((mask_q >> idx_q) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      num_q    <= '0;
      mask_q   <= '0;
      valid_q  <= 1'b0;
      for (int i = 0; i < NumDigits; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
      valid_q  <= res_v;
      if (clear) begin
        num_q  <= '0;
        mask_q <= '0;
        for (int i = 0; i < NumDigits; i++) begin
          cnt_q[i] <= '0;
        end
      end else begin
        if (count_number) begin
          num_q <= sat_inc(num_q);
        end
        for (int i = 0; i < NumDigits; i++) begin
          if (pend_v_q && (pend_d_q == DigitW'(i))) begin
            cnt_q[i]  <= sat_inc(cnt_q[i]);
            mask_q[i] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    pend_d_q <= pend_d_d;
    kind_q   <= res_kind;
    digit_q  <= res_digit;
    tally_q  <= TallyW'(res_cnt);
    last_q   <= res_last;
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign digit_o = digit_q;
  assign tally_o = tally_q;
  assign last_o  = last_q;

  `DDH_ASSERT_IMP(a_pend_digit_range, clk_i, rst_ni, pend_v_q, pend_d_q < DigitW'(NumDigits))
  `DDH_ASSERT_IMP(a_no_pend_in_emit, clk_i, rst_ni, state_q == StEmit, !pend_v_q)
  `DDH_ASSERT_NXT(a_clear_after_last, clk_i, rst_ni, clear, (mask_q == '0) && (num_q == '0))

endmodule

### rtl/decimal_digit_histogram.sv
// Top level of the decimal digit histogram: front end, queue and back end.
//
// The block tallies the decimal digits of signed words given on number_i. A
// word is taken at a rising edge where start_i is high and busy_o is low. A
// non-negative word adds one to the number count and one to the counter of
// each of its decimal digits (zero counts as a single digit 0); it gives no
// result. A negative word ends the session: the block then shows the number
// count (kind_o low, digit_o zero), followed by one result for every digit
// whose counter is nonzero, in ascending digit order, with last_o high on the
// final one, and clears every counter. Each result is on the output ports for
// exactly one cycle, marked by valid_o, and must be taken then, since the
// receiver cannot hold results off. Counters saturate at their largest value.
// Steps: the back end first takes a word from the queue and then gives one
// decimal digit a cycle, by one reciprocal multiplication by ten per digit.
// At a session end the sequencer steps once over the count and each of the
// ten digits; results are registered and appear in the cycle after their
// step. A two-word queue between the front and back ends lets new words be
// taken while a word is being worked on.
module decimal_digit_histogram
  import ddh_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [NumberW-1:0] number_i,
  output logic                      valid_o,
  output logic                      kind_o,
  output logic [DigitW-1:0]         digit_o,
  output logic [TallyW-1:0]         tally_o,
  output logic                      last_o
);

  // Queue head towards the back end, and its pop request.
  item_t item;
  logic  item_valid;
  logic  item_pop;

  ddh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .number_i     (number_i),
    .busy_o       (busy_o),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  ddh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .valid_o      (valid_o),
    .kind_o       (kind_o),
    .digit_o      (digit_o),
    .tally_o      (tally_o),
    .last_o       (last_o)
  );

endmodule
